// ===== src/manchester_frame_transmitter_core_assert.svh =====
// Assertion macros used by the transmitter core.
// Each macro checks a property on the rising edge of aclk, outside reset.
`ifndef MANCHESTER_FRAME_TRANSMITTER_CORE_ASSERT_SVH
`define MANCHESTER_FRAME_TRANSMITTER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define MFT_ASSERT_IMPL(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define MFT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);
`else
`define MFT_ASSERT_IMPL(label, prop, msg)
`define MFT_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// ===== src/mft_pkg.sv =====
package mft_pkg;

    localparam int FRAME_WIDTH = 32;
    localparam int SHIFT_W     = 32;
    localparam int HALF_W      = 14;
    localparam int DELAY_W     = 10;
    localparam int TRIM_W      = 8;
    localparam int CFG_DATA_W  = 14;
    localparam int CFG_IDX_W   = 2;

    localparam logic [HALF_W-1:0]  HALF_RESET  = 14'd8333;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 10'd160;
    localparam logic [TRIM_W-1:0]  TRIM_RESET  = 8'd5;

    localparam logic [16:0] START_SAMPLE_EXTRA = 17'd100;

    localparam logic [7:0] HB_FINAL_HALF = 8'hFF;
    localparam logic [7:0] HB_STOP       = 8'hFE;

    localparam logic [1:0] MODE_START     = 2'd0;
    localparam logic [1:0] MODE_TOGGLE    = 2'd1;
    localparam logic [1:0] MODE_COLLISION = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_TRIM   = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] frame_data;
        logic [5:0]  frame_bits;
        logic        bus_shorted;
    } in_item_t;

    typedef struct packed {
        logic [15:0] next_period;
        logic [15:0] sample_time;
        logic        drive_enable;
        logic        busy_res;
        logic        done_res;
        logic        collided;
    } out_item_t;

    typedef struct packed {
        logic [HALF_W-1:0]  half_bit_ticks;
        logic [DELAY_W-1:0] sample_delay_ticks;
        logic [TRIM_W-1:0]  start_trim_ticks;
    } cfg_t;

    typedef struct packed {
        logic [SHIFT_W-1:0] bit_shifter;
        logic [7:0]         half_bits_remaining;
        logic               previous_bit;
        logic               active;
        logic               driving;
    } tx_state_t;

    function automatic logic [15:0] sat16(input logic [16:0] v);
        return v[16] ? 16'hFFFF : v[15:0];
    endfunction

endpackage

// ===== src/mft_cfg.sv =====
module mft_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [mft_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mft_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output mft_pkg::cfg_t                       cfg
);

    mft_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_bit_ticks     <= mft_pkg::HALF_RESET;
            cfg_reg.sample_delay_ticks <= mft_pkg::DELAY_RESET;
            cfg_reg.start_trim_ticks   <= mft_pkg::TRIM_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                mft_pkg::REG_HALF_BIT: begin
                    cfg_reg.half_bit_ticks <= cfg_wdata[mft_pkg::HALF_W-1:0];
                end
                mft_pkg::REG_SAMPLE_DELAY: begin
                    cfg_reg.sample_delay_ticks <= cfg_wdata[mft_pkg::DELAY_W-1:0];
                end
                mft_pkg::REG_START_TRIM: begin
                    cfg_reg.start_trim_ticks <= cfg_wdata[mft_pkg::TRIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/mft_step.sv =====
module mft_step (
    input  mft_pkg::cfg_t      cfg,
    input  mft_pkg::tx_state_t state,
    input  mft_pkg::in_item_t  item,
    output mft_pkg::tx_state_t state_next,
    output mft_pkg::out_item_t result
);

    logic [mft_pkg::HALF_W-1:0] half;
    logic [7:0]                 hb;
    logic [5:0]                 nbits;
    logic [5:0]                 shift_amt;
    logic [mft_pkg::HALF_W-1:0] first_period;
    logic [16:0]                period;
    logic                       next_bit;

    always_comb begin
        half = (cfg.half_bit_ticks == '0) ? mft_pkg::HALF_W'(1) : cfg.half_bit_ticks;
        hb = state.half_bits_remaining;
        next_bit = state.bit_shifter[mft_pkg::SHIFT_W-1];

        if (item.frame_bits == 6'd0) begin
            nbits = 6'd1;
        end else if (item.frame_bits > 6'(mft_pkg::FRAME_WIDTH)) begin
            nbits = 6'(mft_pkg::FRAME_WIDTH);
        end else begin
            nbits = item.frame_bits;
        end
        shift_amt = 6'(mft_pkg::SHIFT_W) - nbits;

        if (half > mft_pkg::HALF_W'(cfg.start_trim_ticks)) begin
            first_period = half - mft_pkg::HALF_W'(cfg.start_trim_ticks);
        end else begin
            first_period = mft_pkg::HALF_W'(1);
        end

        state_next = state;
        result = '0;
        period = '0;

        case (item.mode)
            mft_pkg::MODE_START: begin
                state_next.bit_shifter = item.frame_data << shift_amt;
                state_next.half_bits_remaining = {1'b0, nbits, 1'b0};
                state_next.previous_bit = 1'b1;
                state_next.active = 1'b1;
                state_next.driving = 1'b1;
                result.next_period = 16'(first_period);
                result.sample_time = mft_pkg::sat16(17'(first_period)
                                                    + mft_pkg::START_SAMPLE_EXTRA);
                result.drive_enable = 1'b1;
                result.busy_res = 1'b1;
            end
            mft_pkg::MODE_TOGGLE: begin
                if (state.active) begin
                    if (hb != 8'd0 && !hb[7]) begin
                        if (!hb[0]) begin
                            state_next.bit_shifter = state.bit_shifter << 1;
                            if (next_bit == state.previous_bit) begin
                                state_next.half_bits_remaining = hb - 8'd1;
                                period = 17'(half);
                            end else begin
                                state_next.half_bits_remaining = hb - 8'd2;
                                period = 17'(half) << 1;
                                state_next.previous_bit = next_bit;
                            end
                        end else begin
                            state_next.half_bits_remaining = hb - 8'd1;
                            period = 17'(half);
                        end
                    end else if (hb == 8'd0) begin
                        if (!state.previous_bit) begin
                            state_next.half_bits_remaining = mft_pkg::HB_FINAL_HALF;
                            period = 17'(half);
                        end else begin
                            state_next.half_bits_remaining = mft_pkg::HB_STOP;
                            state_next.driving = 1'b0;
                            period = (17'(half) << 2) + 17'(half);
                        end
                    end else if (hb == mft_pkg::HB_FINAL_HALF) begin
                        state_next.half_bits_remaining = mft_pkg::HB_STOP;
                        state_next.driving = 1'b0;
                        period = 17'(half) << 2;
                    end else begin
                        state_next.active = 1'b0;
                        state_next.driving = 1'b0;
                        result.done_res = 1'b1;
                    end
                    result.next_period = mft_pkg::sat16(period);
                    result.sample_time = (period == '0) ? 16'd0 :
                        mft_pkg::sat16(17'(mft_pkg::sat16(period))
                                       + 17'(cfg.sample_delay_ticks));
                    result.drive_enable = state_next.driving;
                    result.busy_res = state_next.active;
                end
            end
            mft_pkg::MODE_COLLISION: begin
                if (state.active && item.bus_shorted) begin
                    state_next.active = 1'b0;
                    state_next.driving = 1'b0;
                    result.done_res = 1'b1;
                    result.collided = 1'b1;
                end else begin
                    result.drive_enable = state.driving;
                    result.busy_res = state.active;
                end
            end
            default: begin
                result.drive_enable = state.driving;
                result.busy_res = state.active;
            end
        endcase
    end

endmodule

// ===== src/manchester_frame_transmitter_core.sv =====
// Channel  | Ports                          | Item
// ---------+--------------------------------+-------------------------------------
// input    | s_valid, s_ready, s_item       | event: mode, frame data, bits, short
// result   | m_valid, m_ready, m_item       | period, sample time, drive/busy/done
// config   | cfg_we, cfg_index, cfg_wdata   | register write, no handshake
//
// Each item is taken into an input register, and its result is loaded into the result register
// when it moves on from there; one item per cycle is sustained through both while m_ready holds.
// The frame state is updated when an item moves from the input to the result register.
// Reset (aresetn low, synchronous) empties both registers and returns the line to idle.
// A stalled result holds the input register, and s_ready falls once both are full.
`include "manchester_frame_transmitter_core_assert.svh"

module manchester_frame_transmitter_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  mft_pkg::in_item_t                  s_item,
    output logic                               m_valid,
    input  logic                               m_ready,
    output mft_pkg::out_item_t                 m_item,
    input  logic                               cfg_we,
    input  logic [mft_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mft_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    mft_pkg::cfg_t      cfg;
    mft_pkg::in_item_t  in_reg;
    logic               in_valid_reg;
    mft_pkg::out_item_t out_reg;
    logic               out_valid_reg;
    mft_pkg::tx_state_t state_reg;
    mft_pkg::tx_state_t state_next;
    mft_pkg::out_item_t result;
    logic               advance;
    mft_pkg::out_item_t m_chk;
    logic               start_adv;
    logic               line_up;

    mft_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mft_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (in_reg),
        .state_next (state_next),
        .result     (result)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg.bit_shifter         <= '0;
            state_reg.half_bits_remaining <= '0;
            state_reg.previous_bit        <= 1'b1;
            state_reg.active              <= 1'b0;
            state_reg.driving             <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_item;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_chk     = m_valid ? m_item : '0;
    assign start_adv = advance && (in_reg.mode == mft_pkg::MODE_START);
    assign line_up   = state_reg.active && state_reg.driving;

    `MFT_ASSERT_IMPL(a_drive_busy, !state_reg.driving || state_reg.active, "driven while idle")
    `MFT_ASSERT_IMPL(a_done_not_busy, !(m_chk.done_res && m_chk.busy_res), "done while busy")
    `MFT_ASSERT_IMPL(a_coll_with_done, !m_chk.collided || m_chk.done_res, "collided without done")
    `MFT_ASSERT_NEXT(a_start_goes_busy, start_adv, line_up, "start did not activate frame")

endmodule
